>>> rtl/akh_pkg.sv
// Package: widths, constants and shared types of the anagram key hash block.
package akh_pkg;

  localparam int MaxLen     = 32;
  localparam int CharW      = 7;
  localparam int CntW       = $clog2(MaxLen + 1);
  localparam int HashW      = 32;
  localparam int StepW      = $clog2(HashW);
  localparam int TsW        = 17;
  localparam int BucketW    = 16;
  localparam int HashBase   = 29;
  localparam int LetterBase = 97;
  localparam int TsReset    = 1024;
  localparam int TsMax      = 65536;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SHIFT  = 2'd2
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [CharW-1:0]   ch;
    logic [CntW-1:0]    count;
  } chain_ctrl_t;

endpackage

>>> rtl/akh_if.sv
// Interfaces: character input stream, result stream and table size write channel.
interface akh_in_if import akh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last;
  modport source(output valid, character, last, input ready);
  modport sink(input valid, character, last, output ready);
endinterface

interface akh_out_if import akh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BucketW-1:0] bucket;
  logic               too_long;
  modport source(output valid, bucket, too_long, input ready);
  modport sink(input valid, bucket, too_long, output ready);
endinterface

interface akh_cfg_if import akh_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [TsW-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> rtl/akh_cell.sv
// One cell of the sorted character row: holds one character, inserts or shifts.
module akh_cell import akh_pkg::*; (
  input  logic             clk_i,
  input  cell_cmd_e        cmd_i,
  input  logic [CharW-1:0] ch_i,
  input  logic             occ_i,
  input  logic             at_end_i,
  input  logic             left_gt_i,
  input  logic [CharW-1:0] left_val_i,
  input  logic [CharW-1:0] right_val_i,
  output logic [CharW-1:0] val_o,
  output logic             gt_o
);

  logic [CharW-1:0] val_q, val_d;

  assign gt_o  = occ_i && (val_q > ch_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    unique case (cmd_i)
      CMD_INSERT: begin
        // left neighbor is larger: everything from here up moves one place right
        if (left_gt_i) begin
          val_d = left_val_i;
        end else if (gt_o || at_end_i) begin
          val_d = ch_i;
        end
      end
      CMD_SHIFT: val_d = right_val_i;
      default:   val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> rtl/akh_chain.sv
// Row of character cells kept in ascending order; cell 0 is the head.
module akh_chain import akh_pkg::*; (
  input  logic             clk_i,
  input  chain_ctrl_t      ctrl_i,
  output logic [CharW-1:0] head_o
);

  logic [CharW-1:0] val [MaxLen];
  logic             gt  [MaxLen];

  for (genvar i = 0; i < MaxLen; i++) begin : g_cell
    logic [CharW-1:0] left_val, right_val;
    logic             left_gt;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = val[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == MaxLen - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_body
      assign right_val = val[i+1];
    end

    akh_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (ctrl_i.cmd),
      .ch_i       (ctrl_i.ch),
      .occ_i      (CntW'(i) < ctrl_i.count),
      .at_end_i   (CntW'(i) == ctrl_i.count),
      .left_gt_i  (left_gt),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .val_o      (val[i]),
      .gt_o       (gt[i])
    );
  end

  assign head_o = val[0];

endmodule

>>> rtl/akh_mod.sv
// Restoring remainder unit: 32-bit dividend modulo a 17-bit divisor, one bit a cycle.
module akh_mod import akh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [HashW-1:0]   dividend_i,
  input  logic [TsW-1:0]     divisor_i,
  output logic               done_o,
  output logic [BucketW-1:0] rem_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic [HashW-1:0]   dvd_q, dvd_d;
  logic [TsW-1:0]     dsr_q, dsr_d;
  logic [BucketW-1:0] r_q, r_d;
  logic [TsW-1:0]     r_shift, r_sub;

  // remainder stays below divisor <= 2^16, so the shifted value fits in TsW bits
  assign r_shift = {r_q, dvd_q[HashW-1]};
  assign r_sub   = (r_shift >= dsr_q) ? (r_shift - dsr_q) : r_shift;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      r_d    = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[HashW-2:0], 1'b0};
      r_d   = r_sub[BucketW-1:0];
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(HashW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

>>> rtl/anagram_key_hash.sv
// Anagram key hash: one character per transfer is inserted into a sorted cell row.
// The character marked last is inserted, then the row shifts out through the
// multiply-accumulate, one stored character per cycle (at most 32 stored), then the
// bit-serial remainder unit runs its 32 steps and raises its done flag, and the result
// register loads last: the marked character holds off the next input transfer until
// that load, which waits while an earlier result still waits on out_o.ready.
// Words longer than 32 characters keep the first 32 and report too_long. A table
// size of 0 acts as 1, and sizes above 65536 act as 65536.
module anagram_key_hash import akh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  akh_in_if.sink    in_i,
  akh_out_if.source out_o,
  akh_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic               ovf_q, ovf_d;
  logic               tl_q, tl_d;
  logic [TsW-1:0]     ts_q;
  logic [TsW-1:0]     ts_eff;
  logic [HashW-1:0]   h_q, h_d;
  logic [HashW-1:0]   pow_q, pow_d;
  logic               out_vld_q, out_vld_d;
  logic [BucketW-1:0] bucket_q;
  logic               too_long_q;
  logic               in_xfer, full, out_free, load_out;
  logic               mod_start, mod_done;
  logic [BucketW-1:0] mod_rem;
  logic [CharW-1:0]   head;
  logic signed [CharW:0] diff_s;
  logic [HashW-1:0]   diff_ext, term;
  chain_ctrl_t        ctrl;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign full        = (count_q == CntW'(MaxLen));
  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (ts_q == '0) begin
      ts_eff = TsW'(1);
    end else if (ts_q > TsW'(TsMax)) begin
      ts_eff = TsW'(TsMax);
    end else begin
      ts_eff = ts_q;
    end
  end

  // head character minus 'a', sign-extended: wraps modulo 2^32 like the sum
  assign diff_s   = $signed({1'b0, head}) - $signed((CharW+1)'(LetterBase));
  assign diff_ext = HashW'(diff_s);
  assign term     = diff_ext * pow_q;

  always_comb begin
    ctrl.ch    = in_i.character;
    ctrl.count = count_q;
    ctrl.cmd   = CMD_HOLD;
    if (in_xfer && !full) begin
      ctrl.cmd = CMD_INSERT;
    end else if (state_q == S_WALK) begin
      ctrl.cmd = CMD_SHIFT;
    end
  end

  akh_chain u_chain (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .head_o(head)
  );

  assign mod_start = (state_q == S_WALK) && (rem_q == CntW'(1));

  akh_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(h_d),
    .divisor_i (ts_eff),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign out_free = !out_vld_q || out_o.ready;
  assign load_out = (state_q == S_EMIT) && out_free;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    ovf_d     = ovf_q;
    tl_d      = tl_q;
    h_d       = h_q;
    pow_d     = pow_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (in_i.last) begin
            rem_d   = full ? count_q : count_q + CntW'(1);
            tl_d    = ovf_q || full;
            ovf_d   = 1'b0;
            count_d = '0;
            h_d     = '0;
            pow_d   = HashW'(1);
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        h_d   = h_q + term;
        pow_d = pow_q * HashW'(HashBase);
        rem_d = rem_q - CntW'(1);
        if (rem_q == CntW'(1)) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rem_q     <= '0;
      ovf_q     <= 1'b0;
      tl_q      <= 1'b0;
      out_vld_q <= 1'b0;
      ts_q      <= TsW'(TsReset);
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      ovf_q     <= ovf_d;
      tl_q      <= tl_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        ts_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    pow_q <= pow_d;
    if (load_out) begin
      bucket_q   <= mod_rem;
      too_long_q <= tl_q;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.bucket   = bucket_q;
  assign out_o.too_long = too_long_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxLen))
    else $error("stored character count beyond row length");

  a_last_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.last) |=> (state_q == S_WALK) && (rem_q != '0) && (count_q == '0))
    else $error("marked character did not start the walk");

  a_walk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (rem_q != '0))
    else $error("walk with no characters left");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> ({1'b0, mod_rem} < ts_eff))
    else $error("remainder not below table size");

  // 32 steps, then the done flag registers in the cycle after the last step
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_start |=> ##32 mod_done)
    else $error("remainder unit did not finish on time");

endmodule

>>> verif/anagram_key_hash_tb.sv
// Testbench for anagram_key_hash: directed and random words against a sorted-key hash predictor.
module anagram_key_hash_tb;
  import akh_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 70;
  localparam int NumSegments = 9;
  localparam int SegItems    = 90;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } word_char_t;

  typedef struct packed {
    logic [BucketW-1:0] bucket;
    logic               too_long;
  } bucket_res_t;

  logic clk_i;
  logic rst_ni;

  akh_in_if  in_if();
  akh_out_if out_if();
  akh_cfg_if cfg_if();

  anagram_key_hash dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  word_char_t  char_queue[$];
  bucket_res_t pending_buckets[$];

  // predictor state
  logic [CharW-1:0] word_sorted[MaxLen];
  int unsigned      word_len;
  logic             word_overflow;
  logic [TsW-1:0]   table_size_q;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned chars_sent;
  int unsigned buckets_checked;
  int unsigned cycle_count;
  logic [TsW-1:0] size_plan[NumSegments];

  bucket_res_t exp_res;
  logic        in_take;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Inserts one character into the sorted word; on the marked one,
  // forms the weighted sum and queues the expected bucket.
  function automatic void absorb_char(logic [CharW-1:0] ch, logic lst);
    int unsigned pos;
    logic [HashW-1:0] h;
    logic [HashW-1:0] pw;
    logic [HashW-1:0] c32;
    logic [HashW-1:0] ts;
    bucket_res_t res;
    if (word_len >= MaxLen) begin
      word_overflow = 1'b1;
    end else begin
      pos = word_len;
      while (pos > 0 && word_sorted[pos-1] > ch) begin
        word_sorted[pos] = word_sorted[pos-1];
        pos--;
      end
      word_sorted[pos] = ch;
      word_len++;
    end
    if (lst) begin
      h  = '0;
      pw = HashW'(1);
      for (int i = 0; i < word_len; i++) begin
        c32 = HashW'(word_sorted[i]);
        h   = h + (c32 - HashW'(LetterBase)) * pw;
        pw  = pw * HashW'(HashBase);
      end
      ts = HashW'(table_size_q);
      if (ts == 0) ts = HashW'(1);
      if (ts > HashW'(TsMax)) ts = HashW'(TsMax);
      h = h % ts;
      res.bucket   = h[BucketW-1:0];
      res.too_long = word_overflow;
      pending_buckets = {pending_buckets, res};
      word_len      = 0;
      word_overflow = 1'b0;
    end
  endfunction

  // Input driver: holds valid until the transfer, then idles at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.character <= '0;
      in_if.last      <= 1'b0;
    end else begin
      in_take = in_if.valid && in_if.ready;
      if (in_take) begin
        absorb_char(in_if.character, in_if.last);
        void'(char_queue.pop_front());
        chars_sent++;
      end
      if (in_if.valid && !in_take) begin
        // stall: keep the current item on the bus
      end else if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.character <= char_queue[0].character;
        in_if.last      <= char_queue[0].last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor and backpressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_buckets.size() == 0) begin
          $error("result with no word pending: bucket %0d too_long %0d",
                 out_if.bucket, out_if.too_long);
          fail_count++;
        end else begin
          exp_res = pending_buckets.pop_front();
          buckets_checked++;
          if (out_if.bucket !== exp_res.bucket) begin
            $error("bucket mismatch: expected %0d, actual %0d", exp_res.bucket, out_if.bucket);
            fail_count++;
          end
          if (out_if.too_long !== exp_res.too_long) begin
            $error("too_long mismatch: expected %0d, actual %0d",
                   exp_res.too_long, out_if.too_long);
            fail_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_char(input logic [CharW-1:0] ch, input logic lst);
    word_char_t item;
    item.character = ch;
    item.last      = lst;
    char_queue = {char_queue, item};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(CharW'(s[i]), i == s.len() - 1);
  endtask

  // Mostly short lowercase words, some near or past the store depth.
  task automatic push_random_words(input int n_items);
    int added;
    int len;
    int r;
    logic [CharW-1:0] ch;
    added = 0;
    while (added < n_items) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(10, 1);
      else if (r < 85) len = $urandom_range(31, 11);
      else len = $urandom_range(40, 30);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 75) ch = CharW'(LetterBase + $urandom_range(25));
        else ch = CharW'($urandom_range(127));
        push_char(ch, i == len - 1);
      end
      added += len;
    end
  endtask

  task automatic drain();
    while (char_queue.size() != 0 || pending_buckets.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_table_size(input logic [TsW-1:0] v);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    table_size_q = v;
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    word_len         = 0;
    word_overflow    = 1'b0;
    table_size_q     = TsW'(TsReset);
    send_idle_pct    = 19;
    recv_stall_pct   = 46;
    fail_count       = 0;
    chars_sent       = 0;
    buckets_checked  = 0;
    cycle_count      = 0;

    size_plan[0] = TsW'(1);
    size_plan[1] = TsW'(TsMax);
    size_plan[2] = '0;
    size_plan[3] = '1;
    size_plan[4] = TsW'(7);
    size_plan[5] = TsW'(TsMax - 1);
    size_plan[6] = TsW'($urandom_range(TsMax, 2));
    size_plan[7] = TsW'(TsReset);
    size_plan[8] = TsW'($urandom_range(131071));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words at the reset table size
    push_text("a");
    push_text("dcba");
    push_text("bab");
    push_text("zyx");
    push_char(CharW'(0), 1'b0);
    push_char(CharW'(127), 1'b0);
    push_char(CharW'(127), 1'b1);
    push_char(CharW'(0), 1'b1);
    drain();

    for (int seg = 0; seg < NumSegments; seg++) begin
      if (seg < 3) begin
        send_idle_pct  = 19;
        recv_stall_pct = 46;
      end else if (seg < 6) begin
        send_idle_pct  = 46;
        recv_stall_pct = 19;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_table_size(size_plan[seg]);
      push_random_words(SegItems);
      drain();
    end

    $display("Sent %0d characters, checked %0d buckets over %0d table sizes",
             chars_sent, buckets_checked, NumSegments + 1);
    $display("Covered zero, clamped and extreme table sizes and words past the store depth");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/akh_pkg.sv
rtl/akh_if.sv
rtl/akh_cell.sv
rtl/akh_chain.sv
rtl/akh_mod.sv
rtl/anagram_key_hash.sv
verif/anagram_key_hash_tb.sv
